[src/nprs_pkg.sv]
// Package for the nearest point to ray search block.
// Holds the word types, register codes and reset constants shared by the front, back and top modules.
// No dependencies.
`timescale 1ns / 1ps

package nprs_pkg;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic        hit;
        logic [7:0]  hit_index;
        logic [35:0] hit_dist_sq;
    } result_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } ray_cfg_t;

    typedef struct packed {
        logic signed [16:0] d_x;
        logic signed [16:0] d_y;
        logic signed [16:0] d_z;
        logic signed [19:0] t;
        logic               ahead;
        logic               last_point;
        logic [7:0]         index;
    } mid_t;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_RADIUS   = 3'd6;

    localparam logic signed [15:0] DIR_Z_RESET  = 16'sd16384;
    localparam logic [35:0]        RADIUS_RESET = 36'd65536;
    localparam logic [35:0]        DIST_MAX     = 36'hF_FFFF_FFFF;

endpackage

[src/nprs_fifo.sv]
// Small first-in first-out queue of flip-flop entries.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module nprs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

[src/nprs_front.sv]
// Front end: accepts points, numbers them, forms the offset and the projection t.
// Depends on nprs_pkg; pushes one word per point into the middle queue.
`timescale 1ns / 1ps

module nprs_front #(
    parameter int MAX_POINTS = 256,
    parameter int DEPTH      = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  nprs_pkg::point_t            point,
    output logic                        full,
    input  nprs_pkg::ray_cfg_t          ray,
    input  logic [$clog2(DEPTH+1)-1:0]  q_count,
    output logic                        q_push,
    output nprs_pkg::mid_t              q_word
);
    import nprs_pkg::*;

    localparam int CW      = $clog2(DEPTH+1);
    localparam int WRAP_AT = (MAX_POINTS > 256) ? 256 : MAX_POINTS;

    logic               accept;
    logic [CW:0]        occupancy;
    logic [7:0]         count_reg, count_next;

    logic               s1_valid_reg;
    logic signed [16:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic               s1_last_reg;
    logic [7:0]         s1_index_reg;

    logic               s2_valid_reg;
    logic signed [32:0] s2_px_reg, s2_py_reg, s2_pz_reg;
    logic signed [16:0] s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic               s2_last_reg;
    logic [7:0]         s2_index_reg;

    logic signed [33:0] dot;

    assign occupancy = {1'b0, q_count} + (CW+1)'(s1_valid_reg) + (CW+1)'(s2_valid_reg);
    assign full      = (occupancy >= (CW+1)'(DEPTH));
    assign accept    = push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (point.last_point)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = (count_reg == 8'(WRAP_AT-1)) ? '0 : count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg    <= $signed({point.point_x[15], point.point_x})
                      - $signed({ray.origin_x[15], ray.origin_x});
        s1_dy_reg    <= $signed({point.point_y[15], point.point_y})
                      - $signed({ray.origin_y[15], ray.origin_y});
        s1_dz_reg    <= $signed({point.point_z[15], point.point_z})
                      - $signed({ray.origin_z[15], ray.origin_z});
        s1_last_reg  <= point.last_point;
        s1_index_reg <= count_reg;

        s2_px_reg    <= s1_dx_reg * ray.dir_x;
        s2_py_reg    <= s1_dy_reg * ray.dir_y;
        s2_pz_reg    <= s1_dz_reg * ray.dir_z;
        s2_dx_reg    <= s1_dx_reg;
        s2_dy_reg    <= s1_dy_reg;
        s2_dz_reg    <= s1_dz_reg;
        s2_last_reg  <= s1_last_reg;
        s2_index_reg <= s1_index_reg;
    end

    // floor(dot / 2^14) by arithmetic shift
    assign dot = 34'(s2_px_reg) + 34'(s2_py_reg) + 34'(s2_pz_reg);

    always_comb
    begin
        q_word.d_x        = s2_dx_reg;
        q_word.d_y        = s2_dy_reg;
        q_word.d_z        = s2_dz_reg;
        q_word.t          = dot[33:14];
        q_word.ahead      = !dot[33];
        q_word.last_point = s2_last_reg;
        q_word.index      = s2_index_reg;
    end

    assign q_push = s2_valid_reg;

endmodule

[src/nprs_back.sv]
// Back end: foot of projection, squared distance, compare-and-keep, result.
// Depends on nprs_pkg; pops the middle queue and pushes the output queue.
`timescale 1ns / 1ps

module nprs_back #(
    parameter int OUT_DEPTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nprs_pkg::ray_cfg_t              ray,
    input  logic [35:0]                     radius_sq,
    input  logic                            radius_wr,
    input  logic                            q_empty,
    input  nprs_pkg::mid_t                  q_word,
    output logic                            q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
    output logic                            out_push,
    output nprs_pkg::result_t               out_word
);
    import nprs_pkg::*;

    localparam int OCW = $clog2(OUT_DEPTH+1);

    logic [OCW+1:0]     occupancy;

    logic               b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg;
    logic signed [35:0] b1_fx_reg, b1_fy_reg, b1_fz_reg;
    logic signed [16:0] b1_dx_reg, b1_dy_reg, b1_dz_reg;
    logic signed [20:0] b2_ex_reg, b2_ey_reg, b2_ez_reg;
    logic [39:0]        b3_sx_reg, b3_sy_reg, b3_sz_reg;
    logic [35:0]        b4_dist_reg;
    logic               b1_ahead_reg, b2_ahead_reg, b3_ahead_reg, b4_ahead_reg;
    logic               b1_last_reg, b2_last_reg, b3_last_reg, b4_last_reg;
    logic [7:0]         b1_index_reg, b2_index_reg, b3_index_reg, b4_index_reg;

    logic signed [41:0] sq_x, sq_y, sq_z;
    logic [41:0]        dist_sum;

    logic [35:0]        best_dist_reg, best_dist_next;
    logic [7:0]         best_index_reg, best_index_next;
    logic               found_reg, found_next;
    logic [35:0]        keep_dist;
    logic [7:0]         keep_index;
    logic               keep_found;

    assign occupancy = (OCW+2)'(out_count) + (OCW+2)'(b1_valid_reg) + (OCW+2)'(b2_valid_reg)
                     + (OCW+2)'(b3_valid_reg) + (OCW+2)'(b4_valid_reg);
    assign q_pop     = !q_empty && (occupancy < (OCW+2)'(OUT_DEPTH));

    assign sq_x     = b2_ex_reg * b2_ex_reg;
    assign sq_y     = b2_ey_reg * b2_ey_reg;
    assign sq_z     = b2_ez_reg * b2_ez_reg;
    assign dist_sum = 42'(b3_sx_reg) + 42'(b3_sy_reg) + 42'(b3_sz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= q_pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_fx_reg    <= ray.dir_x * q_word.t;
        b1_fy_reg    <= ray.dir_y * q_word.t;
        b1_fz_reg    <= ray.dir_z * q_word.t;
        b1_dx_reg    <= q_word.d_x;
        b1_dy_reg    <= q_word.d_y;
        b1_dz_reg    <= q_word.d_z;
        b1_ahead_reg <= q_word.ahead;
        b1_last_reg  <= q_word.last_point;
        b1_index_reg <= q_word.index;

        // foot offset is floor(dir * t / 2^14)
        b2_ex_reg    <= 21'(b1_dx_reg) - $signed(b1_fx_reg[34:14]);
        b2_ey_reg    <= 21'(b1_dy_reg) - $signed(b1_fy_reg[34:14]);
        b2_ez_reg    <= 21'(b1_dz_reg) - $signed(b1_fz_reg[34:14]);
        b2_ahead_reg <= b1_ahead_reg;
        b2_last_reg  <= b1_last_reg;
        b2_index_reg <= b1_index_reg;

        b3_sx_reg    <= sq_x[39:0];
        b3_sy_reg    <= sq_y[39:0];
        b3_sz_reg    <= sq_z[39:0];
        b3_ahead_reg <= b2_ahead_reg;
        b3_last_reg  <= b2_last_reg;
        b3_index_reg <= b2_index_reg;

        b4_dist_reg  <= (dist_sum[41:36] != '0) ? DIST_MAX : dist_sum[35:0];
        b4_ahead_reg <= b3_ahead_reg;
        b4_last_reg  <= b3_last_reg;
        b4_index_reg <= b3_index_reg;
    end

    always_comb
    begin
        keep_dist  = best_dist_reg;
        keep_index = best_index_reg;
        keep_found = found_reg;
        if (b4_valid_reg && b4_ahead_reg && (b4_dist_reg < best_dist_reg))
        begin
            keep_dist  = b4_dist_reg;
            keep_index = b4_index_reg;
            keep_found = 1'b1;
        end

        best_dist_next  = keep_dist;
        best_index_next = keep_index;
        found_next      = keep_found;
        if (b4_valid_reg && b4_last_reg)
        begin
            best_dist_next  = radius_sq;
            best_index_next = '0;
            found_next      = 1'b0;
        end
        else if (radius_wr && !found_reg)
        begin
            best_dist_next = radius_sq;
        end

        out_word.hit         = keep_found;
        out_word.hit_index   = keep_found ? keep_index : '0;
        out_word.hit_dist_sq = keep_found ? keep_dist : '0;
    end

    assign out_push = b4_valid_reg && b4_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg  <= RADIUS_RESET;
            best_index_reg <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            best_dist_reg  <= best_dist_next;
            best_index_reg <= best_index_next;
            found_reg      <= found_next;
        end
    end

endmodule

[src/nearest_point_to_ray_search.sv]
// Top level of the nearest point to ray search: register port, queues, front and back.
// Depends on nprs_pkg, nprs_fifo, nprs_front and nprs_back.
//
//   Channel   Handshake            Word
//   point     push / full          nprs_pkg::point_t  (x, y, z Q8.8, last_point)
//   result    pop / empty          nprs_pkg::result_t (hit, hit_index, hit_dist_sq)
//   config    psel/penable/pwrite  64-bit data, register i at byte address 8*i
//
// One point per cycle sustained while full stays low; the figure is set by the
// compare-and-keep register in the back, which takes one squared distance each cycle.
// A result passes the front stages, middle queue, back stages and output queue.
// Reset is asynchronous; no clearing pass, the block takes points right after reset.
// full rises when the middle queue and the two front stages hold four words; the back
// holds off when the output queue and its four stages hold eight.
`timescale 1ns / 1ps

module nearest_point_to_ray_search #(
    parameter int MAX_POINTS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nprs_pkg::point_t   point,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output nprs_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import nprs_pkg::*;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int MCW       = $clog2(MID_DEPTH+1);
    localparam int OCW       = $clog2(OUT_DEPTH+1);

    ray_cfg_t    ray_reg, ray_next;
    logic [35:0] radius_reg, radius_next;
    logic        cfg_wr;
    logic        radius_wr;

    logic        mid_push, mid_pop, mid_empty;
    logic [MCW-1:0] mid_count;
    mid_t        mid_wword, mid_rword;
    logic [$bits(mid_t)-1:0] mid_rdata;

    logic        out_push;
    logic [OCW-1:0] out_count;
    result_t     out_wword;
    logic [$bits(result_t)-1:0] out_rdata;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign radius_wr = cfg_wr && (paddr[5:3] == REG_RADIUS);

    always_comb
    begin
        ray_next    = ray_reg;
        radius_next = radius_reg;
        if (cfg_wr)
        begin
            case (paddr[5:3])
                REG_ORIGIN_X: ray_next.origin_x = pwdata[15:0];
                REG_ORIGIN_Y: ray_next.origin_y = pwdata[15:0];
                REG_ORIGIN_Z: ray_next.origin_z = pwdata[15:0];
                REG_DIR_X:    ray_next.dir_x    = pwdata[15:0];
                REG_DIR_Y:    ray_next.dir_y    = pwdata[15:0];
                REG_DIR_Z:    ray_next.dir_z    = pwdata[15:0];
                REG_RADIUS:   radius_next       = pwdata[35:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg    <= ray_cfg_t'({80'd0, DIR_Z_RESET});
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            ray_reg    <= ray_next;
            radius_reg <= radius_next;
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_ORIGIN_X: prdata = {48'd0, ray_reg.origin_x};
            REG_ORIGIN_Y: prdata = {48'd0, ray_reg.origin_y};
            REG_ORIGIN_Z: prdata = {48'd0, ray_reg.origin_z};
            REG_DIR_X:    prdata = {48'd0, ray_reg.dir_x};
            REG_DIR_Y:    prdata = {48'd0, ray_reg.dir_y};
            REG_DIR_Z:    prdata = {48'd0, ray_reg.dir_z};
            REG_RADIUS:   prdata = {28'd0, radius_reg};
            default:      prdata = '0;
        endcase
    end

    nprs_front #(
        .MAX_POINTS (MAX_POINTS),
        .DEPTH      (MID_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .point   (point),
        .full    (full),
        .ray     (ray_reg),
        .q_count (mid_count),
        .q_push  (mid_push),
        .q_word  (mid_wword)
    );

    nprs_fifo #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wword),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign mid_rword = mid_rdata;

    nprs_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (ray_reg),
        .radius_sq (radius_next),
        .radius_wr (radius_wr),
        .q_empty   (mid_empty),
        .q_word    (mid_rword),
        .q_pop     (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_word  (out_wword)
    );

    nprs_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wword),
        .pop   (pop && !empty),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign result = out_rdata;

    a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> (mid_count < MCW'(MID_DEPTH)))
        else $error("middle queue written while full");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count < OCW'(OUT_DEPTH)))
        else $error("output queue written while full");

    a_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (mid_count < MCW'(MID_DEPTH)))
        else $error("point taken with no room downstream");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.hit) |-> (result.hit_index == '0 && result.hit_dist_sq == '0))
        else $error("miss word carries index or distance");

endmodule
